>>> hdl/arbb_pkg.sv
// shared constants and register index codes for the affine rect bounding box
// no dependencies; imported by the top level, its checker and the testbench files

package arbb_pkg;

    // default coordinate format, signed q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // register stages from request to result strobe
    localparam int PIPE_DEPTH = 5;

    // configuration register file
    localparam int NUM_REGS = 6;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_A  = 3'd0,
        REG_COEF_B  = 3'd1,
        REG_COEF_C  = 3'd2,
        REG_COEF_D  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5
    } reg_idx_t;

    // product slots, one per coefficient and edge pair
    localparam int NUM_PROD = 8;
    localparam int P_AL = 0;
    localparam int P_AR = 1;
    localparam int P_CT = 2;
    localparam int P_CB = 3;
    localparam int P_BL = 4;
    localparam int P_BR = 5;
    localparam int P_DT = 6;
    localparam int P_DB = 7;

endpackage

>>> hdl/affine_rect_bounding_box.sv
// affine rect bounding box top level: apb register file and five-stage datapath
// depends on arbb_pkg
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------------
//  request   | start, busy                 | in_left, in_top, in_right, in_bottom
//  result    | done (one-cycle strobe)     | out_left, out_top, out_right, out_bottom
//  config    | psel, penable, pwrite,      | paddr, pwdata, prdata
//            | pready                      |
//
// one request per cycle; busy is never raised
// each request passes in order through the input register, multiply,
// round, min/max select, add and saturate
// reset clears the valid bits and loads the identity transform
// the receiver cannot stall, so results leave the pipeline as they are made

module affine_rect_bounding_box
    import arbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB   = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W     = ADDR_LSB + REG_IDX_W
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] in_left,
    input  logic signed [COORD_WIDTH-1:0] in_top,
    input  logic signed [COORD_WIDTH-1:0] in_right,
    input  logic signed [COORD_WIDTH-1:0] in_bottom,

    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_left,
    output logic signed [COORD_WIDTH-1:0] out_top,
    output logic signed [COORD_WIDTH-1:0] out_right,
    output logic signed [COORD_WIDTH-1:0] out_bottom,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W;
    localparam int RW  = PW - FRAC_BITS;
    localparam int SW  = RW + 2;
    localparam int HS  = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [PW-1:0] HALF     = (FRAC_BITS > 0) ? (PW'(1) << HS) : '0;
    localparam logic signed [PW-1:0] HALF_NEG = (FRAC_BITS > 0) ? HALF - PW'(1) : '0;
    localparam logic signed [W-1:0]  ONE      = W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0]  SAT_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  SAT_MIN  = {1'b1, {(W-1){1'b0}}};

    // configuration registers
    logic signed [W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [W-1:0] shift_x_reg, shift_y_reg;
    logic                cfg_write;
    reg_idx_t            reg_idx;

    // pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;

    // stage 1: edges
    logic signed [W-1:0] l_reg, t_reg, r_reg, b_reg;

    // stage 2: full products, stage 3: rounded products
    logic signed [PW-1:0] prod_next [NUM_PROD];
    logic signed [PW-1:0] prod_reg  [NUM_PROD];
    logic signed [RW-1:0] rnd_next  [NUM_PROD];
    logic signed [RW-1:0] rnd_reg   [NUM_PROD];
    logic signed [PW-1:0] biased    [NUM_PROD];
    logic signed [PW-1:0] shifted   [NUM_PROD];

    // stage 4: per-term extremes
    logic signed [RW-1:0] ax_min_reg, ax_max_reg, cy_min_reg, cy_max_reg;
    logic signed [RW-1:0] bx_min_reg, bx_max_reg, dy_min_reg, dy_max_reg;

    // stage 5: results
    logic signed [W-1:0] out_left_reg, out_top_reg, out_right_reg, out_bottom_reg;
    logic signed [W-1:0] out_left_next, out_top_next, out_right_next, out_bottom_next;

    function automatic logic signed [W-1:0] sat_sum(input logic signed [SW-1:0] s);
        logic hi_same;
        hi_same = (s[SW-1:W-1] == {(SW-W+1){s[SW-1]}});
        if (hi_same)
            sat_sum = s[W-1:0];
        else if (s[SW-1])
            sat_sum = SAT_MIN;
        else
            sat_sum = SAT_MAX;
    endfunction

    // ---------------- configuration port ----------------

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= ONE;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= ONE;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_COEF_A:  coef_a_reg  <= pwdata[W-1:0];
                REG_COEF_B:  coef_b_reg  <= pwdata[W-1:0];
                REG_COEF_C:  coef_c_reg  <= pwdata[W-1:0];
                REG_COEF_D:  coef_d_reg  <= pwdata[W-1:0];
                REG_SHIFT_X: shift_x_reg <= pwdata[W-1:0];
                REG_SHIFT_Y: shift_y_reg <= pwdata[W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COEF_A:  prdata = DATA_W'(coef_a_reg);
            REG_COEF_B:  prdata = DATA_W'(coef_b_reg);
            REG_COEF_C:  prdata = DATA_W'(coef_c_reg);
            REG_COEF_D:  prdata = DATA_W'(coef_d_reg);
            REG_SHIFT_X: prdata = DATA_W'(shift_x_reg);
            REG_SHIFT_Y: prdata = DATA_W'(shift_y_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------

    assign busy = 1'b0;

    // corners pair every x edge with every y edge, so each output extreme is
    // the sum of the extremes of its two rounded terms (saturation is monotonic)
    always_comb
    begin
        prod_next[P_AL] = PW'(coef_a_reg) * PW'(l_reg);
        prod_next[P_AR] = PW'(coef_a_reg) * PW'(r_reg);
        prod_next[P_CT] = PW'(coef_c_reg) * PW'(t_reg);
        prod_next[P_CB] = PW'(coef_c_reg) * PW'(b_reg);
        prod_next[P_BL] = PW'(coef_b_reg) * PW'(l_reg);
        prod_next[P_BR] = PW'(coef_b_reg) * PW'(r_reg);
        prod_next[P_DT] = PW'(coef_d_reg) * PW'(t_reg);
        prod_next[P_DB] = PW'(coef_d_reg) * PW'(b_reg);
    end

    // round half away from zero: negative products take half minus one
    always_comb
    begin
        for (int i = 0; i < NUM_PROD; i++)
        begin
            biased[i]   = prod_reg[i] + (prod_reg[i][PW-1] ? HALF_NEG : HALF);
            shifted[i]  = biased[i] >>> FRAC_BITS;
            rnd_next[i] = shifted[i][RW-1:0];
        end
    end

    always_comb
    begin
        out_left_next   = sat_sum(SW'(ax_min_reg) + SW'(cy_min_reg) + SW'(shift_x_reg));
        out_right_next  = sat_sum(SW'(ax_max_reg) + SW'(cy_max_reg) + SW'(shift_x_reg));
        out_top_next    = sat_sum(SW'(bx_min_reg) + SW'(dy_min_reg) + SW'(shift_y_reg));
        out_bottom_next = sat_sum(SW'(bx_max_reg) + SW'(dy_max_reg) + SW'(shift_y_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            l_reg <= in_left;
            t_reg <= in_top;
            r_reg <= in_right;
            b_reg <= in_bottom;
        end
        if (v1_reg)
        begin
            for (int i = 0; i < NUM_PROD; i++)
                prod_reg[i] <= prod_next[i];
        end
        if (v2_reg)
        begin
            for (int i = 0; i < NUM_PROD; i++)
                rnd_reg[i] <= rnd_next[i];
        end
        if (v3_reg)
        begin
            ax_min_reg <= (rnd_reg[P_AR] < rnd_reg[P_AL]) ? rnd_reg[P_AR] : rnd_reg[P_AL];
            ax_max_reg <= (rnd_reg[P_AR] > rnd_reg[P_AL]) ? rnd_reg[P_AR] : rnd_reg[P_AL];
            cy_min_reg <= (rnd_reg[P_CB] < rnd_reg[P_CT]) ? rnd_reg[P_CB] : rnd_reg[P_CT];
            cy_max_reg <= (rnd_reg[P_CB] > rnd_reg[P_CT]) ? rnd_reg[P_CB] : rnd_reg[P_CT];
            bx_min_reg <= (rnd_reg[P_BR] < rnd_reg[P_BL]) ? rnd_reg[P_BR] : rnd_reg[P_BL];
            bx_max_reg <= (rnd_reg[P_BR] > rnd_reg[P_BL]) ? rnd_reg[P_BR] : rnd_reg[P_BL];
            dy_min_reg <= (rnd_reg[P_DB] < rnd_reg[P_DT]) ? rnd_reg[P_DB] : rnd_reg[P_DT];
            dy_max_reg <= (rnd_reg[P_DB] > rnd_reg[P_DT]) ? rnd_reg[P_DB] : rnd_reg[P_DT];
        end
        if (v4_reg)
        begin
            out_left_reg   <= out_left_next;
            out_top_reg    <= out_top_next;
            out_right_reg  <= out_right_next;
            out_bottom_reg <= out_bottom_next;
        end
    end

    assign done       = done_reg;
    assign out_left   = out_left_reg;
    assign out_top    = out_top_reg;
    assign out_right  = out_right_reg;
    assign out_bottom = out_bottom_reg;

endmodule

>>> hdl/arbb_checker.sv
// port-level checker for the affine rect bounding box, bound to the top level
// depends on arbb_pkg and affine_rect_bounding_box

module arbb_checker
    import arbb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [COORD_WIDTH-1:0] out_left,
    input logic signed [COORD_WIDTH-1:0] out_top,
    input logic signed [COORD_WIDTH-1:0] out_right,
    input logic signed [COORD_WIDTH-1:0] out_bottom
);

    // every request yields its result at the fixed pipeline depth
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_DEPTH done)
        else $error("request without result at pipeline depth");

    // no result without a request at the pipeline depth
    a_done_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result strobe without matching request");

    // the box is never inverted
    a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_left <= out_right)
        else $error("out_left above out_right");

    a_y_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_top <= out_bottom)
        else $error("out_top above out_bottom");

endmodule

bind affine_rect_bounding_box arbb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_arbb_checker (.*);

>>> tb/arbb_bbox_monitor.sv
`timescale 1ns / 100ps
// watches the request, result and register channels of the affine rect bounding box,
// predicts each box from a shadow copy of the transform registers and compares it
// depends on arbb_pkg

module arbb_bbox_monitor
    import arbb_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    input  logic                                busy,
    input  logic signed [COORD_WIDTH_DEF-1:0]   in_left,
    input  logic signed [COORD_WIDTH_DEF-1:0]   in_top,
    input  logic signed [COORD_WIDTH_DEF-1:0]   in_right,
    input  logic signed [COORD_WIDTH_DEF-1:0]   in_bottom,

    input  logic                                done,
    input  logic signed [COORD_WIDTH_DEF-1:0]   out_left,
    input  logic signed [COORD_WIDTH_DEF-1:0]   out_top,
    input  logic signed [COORD_WIDTH_DEF-1:0]   out_right,
    input  logic signed [COORD_WIDTH_DEF-1:0]   out_bottom,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [REG_IDX_W+1:0]                paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                pready,

    output int                                  errors,
    output int                                  pending,
    output int                                  results
);

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } box_t;

    coord_t xform_reg [NUM_REGS];
    box_t   pending_boxes [$];
    box_t   oldest;
    int     reg_sel;

    // exact product, rounded to nearest with ties away from zero
    function automatic longint rounded_product(coord_t k, coord_t v);
        longint p;
        longint m;
        p = longint'(k) * longint'(v);
        m = (p < 0) ? -p : p;
        m = (m + (longint'(1) <<< (FB - 1))) >>> FB;
        return (p < 0) ? -m : m;
    endfunction

    function automatic coord_t sat_coord(longint s);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (s > hi)
            s = hi;
        else if (s < lo)
            s = lo;
        return s[CW-1:0];
    endfunction

    function automatic coord_t map_axis(coord_t k0, coord_t u, coord_t k1, coord_t v,
                                        coord_t t);
        return sat_coord(rounded_product(k0, u) + rounded_product(k1, v) + longint'(t));
    endfunction

    function automatic box_t map_rect_bounds(coord_t l, coord_t t, coord_t r, coord_t b);
        coord_t px [4];
        coord_t py [4];
        coord_t cx;
        coord_t cy;
        box_t   bx;
        px = '{l, r, r, l};
        py = '{t, t, b, b};
        for (int i = 0; i < 4; i++)
        begin
            cx = map_axis(xform_reg[REG_COEF_A], px[i], xform_reg[REG_COEF_C], py[i],
                          xform_reg[REG_SHIFT_X]);
            cy = map_axis(xform_reg[REG_COEF_B], px[i], xform_reg[REG_COEF_D], py[i],
                          xform_reg[REG_SHIFT_Y]);
            if (i == 0)
            begin
                bx.left  = cx;
                bx.right = cx;
                bx.top    = cy;
                bx.bottom = cy;
            end
            else
            begin
                if (cx < bx.left)   bx.left   = cx;
                if (cx > bx.right)  bx.right  = cx;
                if (cy < bx.top)    bx.top    = cy;
                if (cy > bx.bottom) bx.bottom = cy;
            end
        end
        return bx;
    endfunction

    task automatic check_field(string name, coord_t want, coord_t got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (xform_reg[k])
                xform_reg[k] = '0;
            xform_reg[REG_COEF_A] = coord_t'(1 << FB);
            xform_reg[REG_COEF_D] = coord_t'(1 << FB);
            pending_boxes.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_boxes.size() == 0)
                begin
                    $display("%0t: result strobe with no request outstanding, actual %h %h %h %h",
                             $time, out_left, out_top, out_right, out_bottom);
                    errors++;
                end
                else
                begin
                    oldest = pending_boxes.pop_front();
                    check_field("out_left",   oldest.left,   out_left);
                    check_field("out_top",    oldest.top,    out_top);
                    check_field("out_right",  oldest.right,  out_right);
                    check_field("out_bottom", oldest.bottom, out_bottom);
                    results++;
                end
            end

            if (start && !busy)
                pending_boxes.push_back(map_rect_bounds(in_left, in_top, in_right, in_bottom));

            if (psel && penable && pready)
            begin
                reg_sel = int'(paddr >> 2);
                if (reg_sel < NUM_REGS)
                begin
                    if (pwrite)
                        xform_reg[reg_sel] = pwdata;
                    else if (prdata !== xform_reg[reg_sel])
                    begin
                        $display("%0t: register %0d read expected %h actual %h",
                                 $time, reg_sel, xform_reg[reg_sel], prdata);
                        errors++;
                    end
                end
            end
        end
        pending = pending_boxes.size();
    end

endmodule

>>> tb/affine_rect_bounding_box_tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the affine rect bounding box: register settings over apb,
// directed and random rectangle requests; checking lives in arbb_bbox_monitor
// depends on arbb_pkg, arbb_bbox_monitor and affine_rect_bounding_box

module affine_rect_bounding_box_tb;
    import arbb_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int AW = REG_IDX_W + 2;
    localparam int REG_SPARE_A = NUM_REGS;
    localparam int REG_SPARE_B = NUM_REGS + 1;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hffff_0000;
    localparam logic [31:0] HALF    = 32'h0000_8000;
    localparam logic [31:0] NEG_HALF = 32'hffff_8000;
    localparam logic [31:0] MAX_V   = 32'h7fff_ffff;
    localparam logic [31:0] MIN_V   = 32'h8000_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [CW-1:0]   in_left;
    logic signed [CW-1:0]   in_top;
    logic signed [CW-1:0]   in_right;
    logic signed [CW-1:0]   in_bottom;
    logic                   done;
    logic signed [CW-1:0]   out_left;
    logic signed [CW-1:0]   out_top;
    logic signed [CW-1:0]   out_right;
    logic signed [CW-1:0]   out_bottom;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [AW-1:0]          paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    int errors;
    int pending;
    int results;
    int settings;
    int gap_pct;

    affine_rect_bounding_box u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_left    (in_left),
        .in_top     (in_top),
        .in_right   (in_right),
        .in_bottom  (in_bottom),
        .done       (done),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_right  (out_right),
        .out_bottom (out_bottom),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    arbb_bbox_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_left    (in_left),
        .in_top     (in_top),
        .in_right   (in_right),
        .in_bottom  (in_bottom),
        .done       (done),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_right  (out_right),
        .out_bottom (out_bottom),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .errors     (errors),
        .pending    (pending),
        .results    (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d requests outstanding", $time, pending);
        $display("affine_rect_bounding_box: mismatch");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return MAX_V;
            1:       return MIN_V;
            2, 3:    return int'($urandom_range(0, 13107200)) - 6553600;
            4:       return int'($urandom_range(0, 6)) - 3;
            5:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(11))
            0:       return ONE;
            1:       return NEG_ONE;
            2:       return 32'd0;
            3:       return MAX_V;
            4:       return MIN_V;
            5, 6:    return int'($urandom_range(0, 524288)) - 262144;
            7:       return $urandom_range(1) ? HALF : NEG_HALF;
            8:       return int'($urandom_range(0, 131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge, with the bus left idle after each access
    task automatic apb_access(bit wr, int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= AW'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic load_setting(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                logic [31:0] d, logic [31:0] sx, logic [31:0] sy);
        settle();
        apb_access(1'b1, REG_COEF_A, a);
        apb_access(1'b1, REG_COEF_B, b);
        apb_access(1'b1, REG_COEF_C, c);
        apb_access(1'b1, REG_COEF_D, d);
        apb_access(1'b1, REG_SHIFT_X, sx);
        apb_access(1'b1, REG_SHIFT_Y, sy);
        // writes past the register file must leave it untouched
        if ($urandom_range(1))
            apb_access(1'b1, $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        for (int i = 0; i < NUM_REGS; i++)
            apb_access(1'b0, i, 32'd0);
        settings++;
    endtask

    task automatic send_rect(logic [31:0] l, logic [31:0] t, logic [31:0] r, logic [31:0] b);
        if ($urandom_range(99) < gap_pct)
        begin
            start     <= 1'b0;
            in_left   <= $urandom;
            in_top    <= $urandom;
            in_right  <= $urandom;
            in_bottom <= $urandom;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        start     <= 1'b1;
        in_left   <= l;
        in_top    <= t;
        in_right  <= r;
        in_bottom <= b;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        in_left   = '0;
        in_top    = '0;
        in_right  = '0;
        in_bottom = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        settings  = 0;
        gap_pct   = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity transform out of reset, back to back requests
        send_rect(32'd0, 32'd0, 32'd0, 32'd0);
        send_rect(MAX_V, MAX_V, MAX_V, MAX_V);
        send_rect(MIN_V, MIN_V, MIN_V, MIN_V);
        send_rect(MIN_V, MIN_V, MAX_V, MAX_V);
        send_rect(MAX_V, MAX_V, MIN_V, MIN_V);
        // swapped edges
        send_rect(32'h0005_0000, 32'h0007_0000, 32'hfffd_0000, 32'hfffe_0000);
        send_rect(32'hffff_ffff, 32'd1, 32'd1, 32'hffff_ffff);
        send_rect(32'h1234_5678, 32'h8765_4321, 32'hedcb_a987, 32'h789a_bcde);

        // half coefficients put exact ties on odd coordinates
        load_setting(HALF, NEG_HALF, 32'h0001_8000, NEG_HALF, 32'd0, 32'd0);
        send_rect(32'd1, 32'd3, 32'hffff_ffff, 32'hffff_fffd);
        send_rect(32'hffff_fffb, 32'd7, 32'd5, 32'hffff_fff9);
        send_rect(MAX_V, MIN_V, MIN_V, MAX_V);
        send_rect(32'd3, 32'd1, 32'd1, 32'd3);

        // translation only, saturating both ways
        load_setting(ONE, 32'd0, 32'd0, ONE, MAX_V, MIN_V);
        send_rect(32'd1, 32'd1, 32'd2, 32'd2);
        send_rect(32'hffff_ffff, 32'hffff_ffff, MAX_V, MIN_V);
        send_rect(MIN_V, MAX_V, 32'd0, 32'd0);

        // extreme coefficients
        load_setting(MIN_V, MIN_V, MIN_V, MIN_V, MAX_V, MIN_V);
        send_rect(MIN_V, MIN_V, MAX_V, MAX_V);
        send_rect(MAX_V, MIN_V, MIN_V, MAX_V);
        load_setting(MAX_V, MAX_V, MAX_V, MAX_V, MIN_V, MAX_V);
        send_rect(MIN_V, MIN_V, MAX_V, MAX_V);
        send_rect(32'd1, 32'hffff_ffff, 32'h0000_8000, 32'hffff_8000);

        // random settings; the last phases run without idling
        for (int ph = 0; ph < 12; ph++)
        begin
            load_setting(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_coord(), rand_coord());
            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 25;
                default: gap_pct = 50;
            endcase
            if (ph >= 10)
                gap_pct = 0;
            repeat (170)
                send_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end

        settle();
        $display("%0d boxes compared over %0d transform settings", results, settings);
        $display("covered: identity, rounding ties, saturating shifts, extreme and random coefficients");
        if (errors == 0)
            $display("affine_rect_bounding_box: match");
        else
            $display("affine_rect_bounding_box: mismatch");
        $finish;
    end

endmodule

>>> affine_rect_bounding_box.f
hdl/arbb_pkg.sv
hdl/affine_rect_bounding_box.sv
hdl/arbb_checker.sv
tb/arbb_bbox_monitor.sv
tb/affine_rect_bounding_box_tb.sv
